// File: rtl/sgb_pkg.sv
// sgb_pkg: shared types, codes and constants for the separable blur block
// no dependencies
`default_nettype none
package sgb_pkg;
	localparam int CH_BITS = 16;
	localparam int PIX_BITS = 3 * CH_BITS;
	localparam int WGT_BITS = 17;
	localparam int RAD_BITS = 3;
	localparam int DIM_BITS = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 17;
	localparam int COL_BITS = 7;
	localparam int ROW_BITS = 7;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_W0     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_W1     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_W2     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_W3     = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_W4     = 3'd7;

	// action codes
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// result kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef struct packed {
		logic [1:0]          action;
		logic [COL_BITS-1:0] pixel_col;
		logic [ROW_BITS-1:0] pixel_row;
		logic signed [CH_BITS-1:0] red_in;
		logic signed [CH_BITS-1:0] green_in;
		logic signed [CH_BITS-1:0] blue_in;
	} cmd_word_t;

	typedef struct packed {
		logic                result_kind;
		logic signed [CH_BITS-1:0] red_out;
		logic signed [CH_BITS-1:0] green_out;
		logic signed [CH_BITS-1:0] blue_out;
	} result_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear_acc;   // start a new output pixel
		logic tap_read;    // issue memory read for current tap
		logic tap_mac;     // accumulate returned tap
		logic store_out;   // round, saturate and write the pixel
		logic pass_vert;   // 0: horizontal pass, 1: vertical
	} dp_cmd_t;

	// round to nearest (ties up) at scale 2^16 and saturate to 16 bits
	function automatic logic signed [CH_BITS-1:0] round_sat(input logic signed [39:0] acc);
		logic signed [39:0] q;
		q = (acc + 40'sd32768) >>> 16;
		if (q > 40'sd32767) return 16'sh7fff;
		else if (q < -40'sd32768) return 16'sh8000;
		else return q[CH_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

// File: rtl/sgb_ram.sv
// sgb_ram: generic single-port-write, single-port-read RAM, registered read
// no dependencies
`default_nettype none
module sgb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16384
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/sgb_ctrl.sv
// sgb_ctrl: sequencer that walks pixels and taps of both blur passes
// depends on sgb_pkg
`default_nettype none
module sgb_ctrl #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_RADIUS = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  run,
	input  wire [$clog2(MAX_RADIUS+1)-1:0]  radius,
	input  wire [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
	input  wire [$clog2(MAX_HEIGHT+1)-1:0]  eff_h,
	output logic                 busy,
	output logic                 done,
	output sgb_pkg::dp_cmd_t     cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]    x,
	output logic [$clog2(MAX_HEIGHT)-1:0]   y,
	output logic signed [$clog2(MAX_RADIUS+1)+1:0] tap
);
	import sgb_pkg::*;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int TW = $clog2(MAX_RADIUS+1) + 2;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_TAP   = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_WAIT  = 6'b001000,
		ST_STORE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic vert_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic signed [TW-1:0] tap_q;
	logic mac_q;  // read issued last cycle, data arrives now
	logic signed [TW-1:0] rad_s;
	logic last_x, last_y;

	assign rad_s = TW'(signed'({1'b0, radius}));
	assign last_x = (x_q == XW'(eff_w - 1'b1));
	assign last_y = (y_q == YW'(eff_h - 1'b1));

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vert_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			tap_q <= '0;
			mac_q <= 1'b0;
		end else begin
			mac_q <= (state_q == ST_TAP);
			case (state_q)
				ST_IDLE: begin
					if (run) begin
						state_q <= ST_TAP;
						vert_q <= 1'b0;
						x_q <= '0;
						y_q <= '0;
						tap_q <= -rad_s;
					end
				end
				ST_TAP: begin
					if (tap_q == rad_s) state_q <= ST_DRAIN;
					else tap_q <= tap_q + 1'b1;
				end
				ST_DRAIN: state_q <= ST_WAIT;
				ST_WAIT: state_q <= ST_STORE;
				ST_STORE: begin
					tap_q <= -rad_s;
					if (!last_x) begin
						x_q <= x_q + 1'b1;
						state_q <= ST_TAP;
					end else begin
						x_q <= '0;
						if (!last_y) begin
							y_q <= y_q + 1'b1;
							state_q <= ST_TAP;
						end else begin
							y_q <= '0;
							if (vert_q) state_q <= ST_DONE;
							else begin
								vert_q <= 1'b1;
								state_q <= ST_TAP;
							end
						end
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.clear_acc = (state_q == ST_STORE) || (state_q == ST_IDLE);
		cmd.tap_read  = (state_q == ST_TAP);
		cmd.tap_mac   = mac_q;
		cmd.store_out = (state_q == ST_STORE);
		cmd.pass_vert = vert_q;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign x = x_q;
	assign y = y_q;
	assign tap = tap_q;
endmodule
`default_nettype wire

// File: rtl/sgb_dp.sv
// sgb_dp: image and pass stores, tap address clamp, multiply-accumulate
// depends on sgb_pkg, sgb_ram
`default_nettype none
module sgb_dp #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_RADIUS = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sgb_pkg::dp_cmd_t     cmd,
	input  wire [$clog2(MAX_WIDTH)-1:0]    x,
	input  wire [$clog2(MAX_HEIGHT)-1:0]   y,
	input  wire signed [$clog2(MAX_RADIUS+1)+1:0] tap,
	input  wire [$clog2(MAX_WIDTH+1)-1:0]  eff_w,
	input  wire [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
	input  wire [(MAX_RADIUS+1)*sgb_pkg::WGT_BITS-1:0] weights,
	// host access, valid only while the sequencer is idle
	input  wire                  host_we,
	input  wire [$clog2(MAX_WIDTH)-1:0]  host_col,
	input  wire [$clog2(MAX_HEIGHT)-1:0] host_row,
	input  wire [sgb_pkg::PIX_BITS-1:0]  host_wdata,
	output logic [sgb_pkg::PIX_BITS-1:0] pix_rdata
);
	import sgb_pkg::*;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int TW = $clog2(MAX_RADIUS+1) + 2;
	localparam int DW = $clog2(MAX_RADIUS+1);

	logic [AW-1:0] tap_addr, own_addr, host_addr;
	logic signed [XW+1:0] cx;
	logic signed [YW+1:0] cy;
	logic [XW-1:0] tx;
	logic [YW-1:0] ty;
	logic [TW-1:0] tap_dist;
	logic [DW-1:0] dist_s1;
	logic [WGT_BITS-1:0] wsel;
	logic [PIX_BITS-1:0] img_rd, pass_rd, src_rd;
	logic img_we, pass_we;
	logic [AW-1:0] img_raddr, img_waddr;
	logic [PIX_BITS-1:0] img_wdata, out_pix;
	logic signed [39:0] acc_q [3];
	logic signed [CH_BITS+WGT_BITS:0] prod_s2 [3];
	logic prod_v_s2;

	// clamped tap coordinate
	always_comb begin
		cx = (XW+2)'(signed'({2'b0, x})) + (cmd.pass_vert ? '0 : (XW+2)'(tap));
		cy = (YW+2)'(signed'({2'b0, y})) + (cmd.pass_vert ? (YW+2)'(tap) : '0);
		if (cx < 0) tx = '0;
		else if (cx > (XW+2)'(signed'({1'b0, eff_w})) - 1) tx = XW'(eff_w - 1'b1);
		else tx = cx[XW-1:0];
		if (cy < 0) ty = '0;
		else if (cy > (YW+2)'(signed'({1'b0, eff_h})) - 1) ty = YW'(eff_h - 1'b1);
		else ty = cy[YW-1:0];
		tap_addr = {ty, tx};
		own_addr = {y, x};
		host_addr = {host_row, host_col};
		tap_dist = tap[TW-1] ? TW'(-tap) : TW'(tap);
	end

	// store port steering
	assign img_raddr = cmd.tap_read ? tap_addr : host_addr;
	assign img_we    = host_we || (cmd.store_out && cmd.pass_vert);
	assign img_waddr = host_we ? host_addr : own_addr;
	assign img_wdata = host_we ? host_wdata : out_pix;
	assign pass_we   = cmd.store_out && !cmd.pass_vert;

	sgb_ram #(.WIDTH(PIX_BITS), .DEPTH(1 << AW)) u_img (
		.clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
		.raddr(img_raddr), .rdata(img_rd)
	);
	sgb_ram #(.WIDTH(PIX_BITS), .DEPTH(1 << AW)) u_pass (
		.clk(clk), .we(pass_we), .waddr(own_addr), .wdata(out_pix),
		.raddr(tap_addr), .rdata(pass_rd)
	);

	assign pix_rdata = img_rd;
	assign src_rd = cmd.pass_vert ? pass_rd : img_rd;
	assign wsel = weights[dist_s1*WGT_BITS +: WGT_BITS];

	// weight index is registered alongside the read so it meets the returned data; product registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_s1 <= '0;
			prod_v_s2 <= 1'b0;
		end else begin
			dist_s1 <= DW'(tap_dist);
			prod_v_s2 <= cmd.tap_mac;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			prod_s2[c] <= $signed(src_rd[(2-c)*CH_BITS +: CH_BITS])
				* $signed({1'b0, wsel});
		end
	end

	// accumulate; store_out comes in the cycle after the last product is accumulated
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (cmd.clear_acc && !prod_v_s2) acc_q[c] <= '0;
			else if (prod_v_s2) acc_q[c] <= acc_q[c] + 40'(prod_s2[c]);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++)
			out_pix[(2-c)*CH_BITS +: CH_BITS] = round_sat(acc_q[c]);
	end
endmodule
`default_nettype wire

// File: rtl/separable_gaussian_blur.sv
// separable_gaussian_blur: top level, configuration registers and command decode
// depends on sgb_pkg, sgb_ctrl, sgb_dp, sgb_ram
`default_nettype none
// Pixel write and read commands are taken one per cycle whenever busy is low;
// read data appears with done_strobe after the RAM read and output registers,
// and the receiver cannot stall it. A run command keeps busy high while the
// sequencer walks the image twice, one tap per cycle through the store read
// port, then drains, waits and stores each pixel; the finished word is strobed once.
module separable_gaussian_blur #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_RADIUS = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  sgb_pkg::cmd_word_t     cmd,
	output logic                   done_strobe,
	output sgb_pkg::result_word_t  result,
	input  wire                    cfg_we,
	input  wire [sgb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [sgb_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import sgb_pkg::*;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int RW = $clog2(MAX_RADIUS+1);
	localparam int EW = $clog2(MAX_WIDTH+1);
	localparam int EH = $clog2(MAX_HEIGHT+1);

	logic [RAD_BITS-1:0] radius_q;
	logic [DIM_BITS-1:0] width_q, height_q;
	logic [WGT_BITS-1:0] wgt_q [5];
	logic [RW-1:0] radius_eff;
	logic [EW-1:0] eff_w;
	logic [EH-1:0] eff_h;
	logic [(MAX_RADIUS+1)*WGT_BITS-1:0] weights;
	logic accept, in_area, run, host_we, host_re;
	logic rd_s1, in_s1;
	logic seq_busy, seq_done;
	dp_cmd_t dcmd;
	logic [XW-1:0] sx;
	logic [YW-1:0] sy;
	logic signed [RW+1:0] stap;
	logic [PIX_BITS-1:0] rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			width_q <= 8'd128;
			height_q <= 8'd128;
			wgt_q[0] <= 17'd65536;
			for (int i = 1; i < 5; i++) wgt_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[RAD_BITS-1:0];
				REG_WIDTH:  width_q <= cfg_data[DIM_BITS-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_BITS-1:0];
				REG_W0:     wgt_q[0] <= cfg_data;
				REG_W1:     wgt_q[1] <= cfg_data;
				REG_W2:     wgt_q[2] <= cfg_data;
				REG_W3:     wgt_q[3] <= cfg_data;
				REG_W4:     wgt_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective sizes and radius
	always_comb begin
		radius_eff = (radius_q > RAD_BITS'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_q);
		if (width_q == '0) eff_w = EW'(1);
		else if (32'(width_q) > MAX_WIDTH) eff_w = EW'(MAX_WIDTH);
		else eff_w = EW'(width_q);
		if (height_q == '0) eff_h = EH'(1);
		else if (32'(height_q) > MAX_HEIGHT) eff_h = EH'(MAX_HEIGHT);
		else eff_h = EH'(height_q);
		for (int i = 0; i <= MAX_RADIUS; i++)
			weights[i*WGT_BITS +: WGT_BITS] = wgt_q[i];
	end

	// command decode
	assign accept = start && !busy;
	assign in_area = (32'(cmd.pixel_col) < 32'(eff_w)) && (32'(cmd.pixel_row) < 32'(eff_h));
	assign run = accept && (cmd.action == ACT_RUN);
	assign host_we = accept && (cmd.action == ACT_WRITE) && in_area;
	assign host_re = accept && (cmd.action == ACT_READ);

	sgb_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .run(run), .radius(radius_eff),
		.eff_w(eff_w), .eff_h(eff_h), .busy(seq_busy), .done(seq_done),
		.cmd(dcmd), .x(sx), .y(sy), .tap(stap)
	);

	sgb_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dcmd), .x(sx), .y(sy), .tap(stap),
		.eff_w(eff_w), .eff_h(eff_h), .weights(weights),
		.host_we(host_we),
		.host_col(XW'(cmd.pixel_col)), .host_row(YW'(cmd.pixel_row)),
		.host_wdata({cmd.red_in, cmd.green_in, cmd.blue_in}), .pix_rdata(rdata)
	);

	assign busy = seq_busy;

	// read word pipeline: ram read, then output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			in_s1 <= 1'b0;
			done_strobe <= 1'b0;
		end else begin
			rd_s1 <= host_re;
			in_s1 <= in_area;
			done_strobe <= rd_s1 || seq_done;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) result <= {KIND_DONE, {PIX_BITS{1'b0}}};
		else result <= {KIND_PIXEL, in_s1 ? rdata : {PIX_BITS{1'b0}}};
	end

	// a read and a finished run never collide
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_s1 && seq_done))
		else $error("read word and done word collide");
	// a run raises busy on the next edge
	assert property (@(posedge clk) disable iff (!arst_n) run |=> busy)
		else $error("run not started");
	// the sequencer never writes the image while a host write lands
	assert property (@(posedge clk) disable iff (!arst_n) host_we |-> !seq_busy)
		else $error("host write during run");
	// read word follows read command
	assert property (@(posedge clk) disable iff (!arst_n) host_re |=> ##1 done_strobe)
		else $error("read word missing");
endmodule
`default_nettype wire

// File: tb/sv/sgb_checker.sv
// sgb_checker: watches the command, result and register ports of the blur block,
// predicts every result word and compares it. depends on sgb_pkg
`default_nettype none
module sgb_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire                   busy,
	input  sgb_pkg::cmd_word_t    cmd,
	input  wire                   done_strobe,
	input  sgb_pkg::result_word_t result,
	input  wire                   cfg_we,
	input  wire [sgb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [sgb_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	import sgb_pkg::*;

	localparam int MAXW = 128;
	localparam int MAXH = 128;
	localparam int MAXR = 4;
	localparam int DEPTH = MAXW * MAXH;

	// shadow copy of the image, the intermediate pass and the registers
	logic signed [CH_BITS-1:0] img_mem [3][DEPTH];
	logic signed [CH_BITS-1:0] tmp_mem [3][DEPTH];
	logic [RAD_BITS-1:0] radius_reg;
	logic [DIM_BITS-1:0] width_reg;
	logic [DIM_BITS-1:0] height_reg;
	logic [WGT_BITS-1:0] tap_wt [5];
	result_word_t expected_words[$];

	assign pending = expected_words.size();

	function automatic int eff_dim(input int v, input int m);
		if (v == 0) return 1;
		if (v > m) return m;
		return v;
	endfunction

	function automatic int clampc(input int v, input int n);
		if (v < 0) return 0;
		if (v > n - 1) return n - 1;
		return v;
	endfunction

	// round to nearest with ties up, then saturate
	function automatic logic signed [CH_BITS-1:0] round_clip(input longint acc);
		longint q;
		q = (acc + 64'sd32768) >>> 16;
		if (q > 32767) return 16'sh7fff;
		if (q < -32768) return 16'sh8000;
		return q[CH_BITS-1:0];
	endfunction

	// one filter pass, horizontal reads img into tmp, vertical reads tmp into img
	task automatic blur_pass(input bit vert, input int w, input int h, input int r);
		longint acc;
		int xx;
		int yy;
		int d;
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				for (int c = 0; c < 3; c++) begin
					acc = 0;
					for (int t = -r; t <= r; t++) begin
						xx = vert ? x : clampc(x + t, w);
						yy = vert ? clampc(y + t, h) : y;
						d = t < 0 ? -t : t;
						if (vert)
							acc += longint'(tmp_mem[c][yy*MAXW+xx]) * longint'(tap_wt[d]);
						else
							acc += longint'(img_mem[c][yy*MAXW+xx]) * longint'(tap_wt[d]);
					end
					if (vert) img_mem[c][y*MAXW+x] = round_clip(acc);
					else tmp_mem[c][y*MAXW+x] = round_clip(acc);
				end
	endtask

	// register shadow and command prediction
	always @(posedge clk or negedge arst_n) begin
		int w;
		int h;
		int r;
		int idx;
		bit in_area;
		result_word_t rw;
		if (!arst_n) begin
			radius_reg <= '0;
			width_reg <= 8'd128;
			height_reg <= 8'd128;
			tap_wt[0] <= 17'd65536;
			for (int i = 1; i < 5; i++) tap_wt[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS: radius_reg <= cfg_data[RAD_BITS-1:0];
					REG_WIDTH:  width_reg <= cfg_data[DIM_BITS-1:0];
					REG_HEIGHT: height_reg <= cfg_data[DIM_BITS-1:0];
					default:    tap_wt[cfg_index - REG_W0] <= cfg_data;
				endcase
			end
			if (start && !busy) begin
				w = eff_dim(width_reg, MAXW);
				h = eff_dim(height_reg, MAXH);
				r = radius_reg > MAXR ? MAXR : radius_reg;
				in_area = cmd.pixel_col < w && cmd.pixel_row < h;
				idx = cmd.pixel_row * MAXW + cmd.pixel_col;
				rw = '0;
				case (cmd.action)
					ACT_WRITE: if (in_area) begin
						img_mem[0][idx] = cmd.red_in;
						img_mem[1][idx] = cmd.green_in;
						img_mem[2][idx] = cmd.blue_in;
					end
					ACT_RUN: begin
						blur_pass(1'b0, w, h, r);
						blur_pass(1'b1, w, h, r);
						rw.result_kind = KIND_DONE;
						expected_words.push_back(rw);
					end
					ACT_READ: begin
						rw.result_kind = KIND_PIXEL;
						if (in_area) begin
							rw.red_out = img_mem[0][idx];
							rw.green_out = img_mem[1][idx];
							rw.blue_out = img_mem[2][idx];
						end
						expected_words.push_back(rw);
					end
					default: ;
				endcase
			end
		end
	end

	// compare each result word with the oldest prediction
	initial errors = 0;
	always @(posedge clk) begin
		result_word_t ew;
		if (arst_n && done_strobe) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word %h", result);
				errors++;
			end else begin
				ew = expected_words.pop_front();
				if (result.result_kind !== ew.result_kind) begin
					$error("result_kind: expected %0d, got %0d", ew.result_kind,
						result.result_kind);
					errors++;
				end
				if (result.red_out !== ew.red_out) begin
					$error("red_out: expected %0d, got %0d", ew.red_out, result.red_out);
					errors++;
				end
				if (result.green_out !== ew.green_out) begin
					$error("green_out: expected %0d, got %0d", ew.green_out, result.green_out);
					errors++;
				end
				if (result.blue_out !== ew.blue_out) begin
					$error("blue_out: expected %0d, got %0d", ew.blue_out, result.blue_out);
					errors++;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb_separable_gaussian_blur.sv
// tb_separable_gaussian_blur: drives pixel, read and blur commands and register
// settings into the block. depends on sgb_pkg, separable_gaussian_blur, sgb_checker
`default_nettype none
module tb_separable_gaussian_blur;
	import sgb_pkg::*;

	localparam int MAXW = 128;
	localparam int MAXH = 128;
	// unused action code, ignored by the block
	localparam logic [1:0] ACT_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_word_t cmd = '0;
	logic done_strobe;
	result_word_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int errors;
	int pending;

	// which pixels hold a defined value, and the sizes in force
	bit written [MAXW*MAXH];
	int cur_w = MAXW;
	int cur_h = MAXH;
	int gap_pct = 9;

	separable_gaussian_blur dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done_strobe(done_strobe), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sgb_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done_strobe(done_strobe), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

	// present one word and hold it until the block takes it
	task automatic issue(input cmd_word_t c);
		bit taken;
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		if (c.action == ACT_WRITE && c.pixel_col < cur_w && c.pixel_row < cur_h)
			written[c.pixel_row*MAXW + c.pixel_col] = 1;
	endtask

	task automatic put_pixel(input int col, input int row);
		cmd_word_t c;
		c = '0;
		c.action = ACT_WRITE;
		c.pixel_col = COL_BITS'(col);
		c.pixel_row = ROW_BITS'(row);
		c.red_in = CH_BITS'($urandom);
		c.green_in = CH_BITS'($urandom);
		c.blue_in = CH_BITS'($urandom);
		issue(c);
	endtask

	task automatic get_pixel(input int col, input int row);
		cmd_word_t c;
		c = {$urandom, $urandom};
		c.action = ACT_READ;
		c.pixel_col = COL_BITS'(col);
		c.pixel_row = ROW_BITS'(row);
		issue(c);
	endtask

	// every pixel of the area gets a value before a blur
	task automatic blur_image();
		cmd_word_t c;
		for (int y = 0; y < cur_h; y++)
			for (int x = 0; x < cur_w; x++)
				if (!written[y*MAXW + x]) put_pixel(x, y);
		c = {$urandom, $urandom};
		c.action = ACT_RUN;
		issue(c);
	endtask

	// register write, only with the block drained
	task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(val);
		@(posedge clk);
	endtask

	function automatic int eff_dim(input int v, input int m);
		if (v == 0) return 1;
		if (v > m) return m;
		return v;
	endfunction

	task automatic configure(input int r, input int w, input int h, input int w0,
		input int w1, input int w2, input int w3, input int w4);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		set_reg(REG_RADIUS, r);
		set_reg(REG_WIDTH, w);
		set_reg(REG_HEIGHT, h);
		set_reg(REG_W0, w0);
		set_reg(REG_W1, w1);
		set_reg(REG_W2, w2);
		set_reg(REG_W3, w3);
		set_reg(REG_W4, w4);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_w = eff_dim(w, MAXW);
		cur_h = eff_dim(h, MAXH);
	endtask

	function automatic int rand_weight();
		case ($urandom_range(5))
			0: return 0;
			1: return 65536;
			2: return 131071;
			default: return $urandom_range(40000);
		endcase
	endfunction

	function automatic int rand_dim();
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			2: return 128;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	// mixed traffic, mostly within the current size
	task automatic traffic(input int n);
		cmd_word_t c;
		int x;
		int y;
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			x = $urandom_range(cur_w - 1);
			y = $urandom_range(cur_h - 1);
			if (p < 10 && (cur_w < MAXW || cur_h < MAXH)) begin
				// outside the area, write or read
				do begin
					x = $urandom_range(127);
					y = $urandom_range(127);
				end while (x < cur_w && y < cur_h);
				if (p < 5) put_pixel(x, y);
				else get_pixel(x, y);
			end else if (p < 13) begin
				c = {$urandom, $urandom};
				c.action = ACT_SPARE;
				issue(c);
			end else if (p < 16) begin
				blur_image();
			end else if (p < 55 || !written[y*MAXW + x]) begin
				put_pixel(x, y);
			end else begin
				get_pixel(x, y);
			end
		end
	endtask

	initial begin
		int w;
		int h;
		cmd_word_t c;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: far corner extremes under reset settings
		c = '0;
		c.action = ACT_WRITE;
		c.pixel_col = 127;
		c.pixel_row = 127;
		c.red_in = 16'sh7fff;
		c.green_in = 16'sh8000;
		c.blue_in = 16'sh0000;
		issue(c);
		c.pixel_col = 0;
		c.pixel_row = 0;
		c.red_in = 16'sh8000;
		c.green_in = 16'sh7fff;
		c.blue_in = 16'shffff;
		issue(c);
		get_pixel(127, 127);
		get_pixel(0, 0);
		c = '1;
		issue(c);

		// directed: small image, outside writes ignored, reads give zero
		configure(0, 4, 3, 65536, 0, 0, 0, 0);
		put_pixel(127, 0);
		put_pixel(0, 127);
		get_pixel(127, 0);
		get_pixel(4, 2);
		get_pixel(0, 0);
		blur_image();
		get_pixel(3, 2);
		configure(7, 5, 2, 131071, 131071, 131071, 131071, 131071);
		blur_image();
		get_pixel(4, 1);
		get_pixel(0, 0);

		// random phases: occasional sender gaps, then more frequent gaps, then none
		for (int ph = 0; ph < 12; ph++) begin
			gap_pct = ph < 8 ? 9 : (ph < 10 ? 53 : 0);
			if (ph == 0) begin
				w = 255; h = 1;
			end else if (ph == 1) begin
				w = 1; h = 128;
			end else if (ph == 2) begin
				w = 0; h = 0;
			end else begin
				do begin
					w = rand_dim();
					h = rand_dim();
				end while (eff_dim(w, MAXW) * eff_dim(h, MAXH) > 256);
			end
			configure($urandom_range(7), w, h, rand_weight(), rand_weight(),
				rand_weight(), rand_weight(), rand_weight());
			traffic(120);
			blur_image();
			get_pixel(0, 0);
		end

		// drain and give the verdict
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
